// File: src/pcar_pkg.sv
// pcar_pkg: types, codes and default sizes for the pci configuration access router
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcar_pkg;

   localparam int ROUTE_INDEX_BITS_DEF = 16;
   localparam int SERVER_ID_BITS_DEF   = 16;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNHANDLED   = 2'd1;
   localparam logic [1:0] ST_BAD_SEGMENT = 2'd2;
   localparam logic [1:0] ST_EXISTS      = 2'd3;

   localparam logic       MODE_PORT     = 1'b0;
   localparam logic       MODE_REGISTER = 1'b1;

   localparam logic [2:0] LATCH_OFFSET = 3'd0;
   localparam logic [2:0] LATCH_BYTES  = 3'd4;

   typedef enum logic {
      PCAR_IDLE,
      PCAR_LOOKUP
   } pcar_state_type;

   typedef struct packed {
      logic        mode;
      logic        is_write;
      logic [2:0]  port_offset;
      logic [2:0]  access_bytes;
      logic [31:0] write_data;
      logic [15:0] pci_segment;
      logic [7:0]  bus_number;
      logic [4:0]  device_number;
      logic [2:0]  function_number;
      logic [15:0] server_id;
   } pcar_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_data;
      logic        forward_valid;
      logic [15:0] forward_server;
      logic [31:0] forward_address;
      logic [17:0] forward_size_word;
   } pcar_rsp_type;

endpackage

`default_nettype wire

// File: src/pcar_route_table.sv
// pcar_route_table: routing memory, one entry per bus/device/function
// holds a valid flag and the owning server; clears itself after reset
`timescale 1ns / 1ps
`default_nettype none

module pcar_route_table #(
   parameter int ROUTE_INDEX_BITS = pcar_pkg::ROUTE_INDEX_BITS_DEF,
   parameter int SERVER_ID_BITS   = pcar_pkg::SERVER_ID_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   output logic                             ready,
   input  wire logic                        rd_en,
   input  wire logic [ROUTE_INDEX_BITS-1:0] rd_index,
   output logic                             rd_hit,
   output logic [SERVER_ID_BITS-1:0]        rd_server,
   input  wire logic                        wr_en,
   input  wire logic [ROUTE_INDEX_BITS-1:0] wr_index,
   input  wire logic [SERVER_ID_BITS-1:0]   wr_server
);
   import pcar_pkg::*;

   localparam int DEPTH = 1 << ROUTE_INDEX_BITS;

   logic [SERVER_ID_BITS:0]   mem [DEPTH];
   logic [SERVER_ID_BITS:0]   entry_ff;
   logic [ROUTE_INDEX_BITS-1:0] clr_ff, clr_in;
   logic                        busy_ff, busy_in;

   logic                        mem_we;
   logic [ROUTE_INDEX_BITS-1:0] mem_wa;
   logic [SERVER_ID_BITS:0]     mem_wd;

   // clearing sweep, one entry a cycle
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == {ROUTE_INDEX_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      if (busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = '0;
      end else begin
         mem_we = wr_en;
         mem_wa = wr_index;
         mem_wd = {1'b1, wr_server};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         entry_ff <= mem[rd_index];
      end
   end

   assign ready     = !busy_ff;
   assign rd_hit    = entry_ff[SERVER_ID_BITS];
   assign rd_server = entry_ff[SERVER_ID_BITS-1:0];

endmodule

`default_nettype wire

// File: src/pci_config_access_router.sv
// pci_config_access_router: top level, address latch, sequencer and result register
// depends on pcar_pkg and pcar_route_table
// the result is registered as the lookup state finishes; the lookup waits while an
//   earlier result is still undelivered
// one transaction at a time: no new request is taken until the lookup state is left
// a result waiting at the output does not block acceptance of the next request
// reset: synchronous; latch cleared, then a clearing pass over all 2**ROUTE_INDEX_BITS
//   table entries (65536 by default) during which no request is accepted
`timescale 1ns / 1ps
`default_nettype none

module pci_config_access_router #(
   parameter int ROUTE_INDEX_BITS = pcar_pkg::ROUTE_INDEX_BITS_DEF,
   parameter int SERVER_ID_BITS   = pcar_pkg::SERVER_ID_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pcar_pkg::pcar_req_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pcar_pkg::pcar_rsp_type     rsp_data
);
   import pcar_pkg::*;

   pcar_state_type state_ff, state_in;
   pcar_req_type   req_ff;
   pcar_rsp_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    latch_ff, latch_in;

   logic                        tbl_ready;
   logic                        rd_en;
   logic [ROUTE_INDEX_BITS-1:0] rd_index;
   logic                        rd_hit;
   logic [SERVER_ID_BITS-1:0]   rd_server;
   logic                        wr_en;
   logic [ROUTE_INDEX_BITS-1:0] wr_index;
   logic                        finish;
   logic                        accept;
   logic [15:0]                 req_bdf;
   logic [15:0]                 ff_bdf;

   pcar_route_table #(
      .ROUTE_INDEX_BITS(ROUTE_INDEX_BITS),
      .SERVER_ID_BITS  (SERVER_ID_BITS)
   ) u_route_table (
      .clock    (clock),
      .reset    (reset),
      .ready    (tbl_ready),
      .rd_en    (rd_en),
      .rd_index (rd_index),
      .rd_hit   (rd_hit),
      .rd_server(rd_server),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_server(req_ff.server_id[SERVER_ID_BITS-1:0])
   );

   assign accept  = req_valid && req_ready;
   assign req_bdf = {req_data.bus_number, req_data.device_number, req_data.function_number};
   assign ff_bdf  = {req_ff.bus_number, req_ff.device_number, req_ff.function_number};

   assign rd_en    = accept;
   assign rd_index = (req_data.mode == MODE_REGISTER) ? req_bdf[ROUTE_INDEX_BITS-1:0]
                                                      : latch_ff[8 +: ROUTE_INDEX_BITS];
   assign wr_index = ff_bdf[ROUTE_INDEX_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      finish       = 1'b0;
      wr_en        = 1'b0;
      latch_in     = latch_ff;
      rsp_in       = '0;
      rsp_in.status = ST_OK;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (req_ff.mode == MODE_REGISTER) begin
         if (req_ff.pci_segment != 16'd0) begin
            rsp_in.status = ST_BAD_SEGMENT;
         end else if (rd_hit) begin
            rsp_in.status = ST_EXISTS;
         end
      end else if (req_ff.port_offset == LATCH_OFFSET &&
                   req_ff.access_bytes == LATCH_BYTES) begin
         if (!req_ff.is_write) begin
            rsp_in.read_data = latch_ff;
         end
      end else if (!req_ff.port_offset[2]) begin
         rsp_in.status = ST_UNHANDLED;
      end else if (!rd_hit) begin
         rsp_in.read_data = '1;
      end else begin
         rsp_in.forward_valid     = 1'b1;
         rsp_in.forward_server    = 16'(rd_server);
         rsp_in.forward_address   = latch_ff;
         rsp_in.forward_size_word = {req_ff.port_offset[1:0], 13'd0, req_ff.access_bytes};
      end

      unique case (state_ff)
         PCAR_IDLE: begin
            req_ready = tbl_ready;
            if (accept) begin
               state_in = PCAR_LOOKUP;
            end
         end
         PCAR_LOOKUP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = PCAR_IDLE;
               if (req_ff.mode == MODE_REGISTER) begin
                  wr_en = (req_ff.pci_segment == 16'd0) && !rd_hit;
               end else if (req_ff.port_offset == LATCH_OFFSET &&
                            req_ff.access_bytes == LATCH_BYTES && req_ff.is_write) begin
                  latch_in = req_ff.write_data;
               end
            end
         end
         default: begin
            state_in = PCAR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PCAR_IDLE;
         rsp_valid_ff <= 1'b0;
         latch_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         latch_ff     <= latch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // table writes only at the end of a registration lookup
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == PCAR_LOOKUP && req_ff.mode == MODE_REGISTER))
      else $error("route table written outside a registration");

   // no request taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      !tbl_ready |-> !req_ready)
      else $error("request accepted while table clearing");

   // an accepted request is looked up in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == PCAR_LOOKUP))
      else $error("lookup did not follow acceptance");

   // a finished transaction never overwrites a result still waiting
   assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before delivery");

   // forwarded transactions carry ok status and no read data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.forward_valid) |-> (rsp_ff.status == ST_OK &&
                                                  rsp_ff.read_data == 32'd0))
      else $error("forwarded transaction with bad status or data");

endmodule

`default_nettype wire

// File: sim/tb_pci_config_access_router.sv
// tb_pci_config_access_router: self-checking testbench for the pci configuration access router
// predicts latch, routing table and forwarding behaviour in step with accepted transactions
// depends on pcar_pkg and pci_config_access_router
`timescale 1ns / 1ps

module tb_pci_config_access_router;
   import pcar_pkg::*;

   localparam logic [2:0] DATA_OFFSET = 3'd4;
   localparam int         ROUTE_DEPTH = 1 << ROUTE_INDEX_BITS_DEF;
   localparam int         TOTAL_ITEMS = 1330;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   pcar_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   pcar_rsp_type rsp_data;

   pci_config_access_router dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the block's state
   logic [31:0]  cf8_latch = '0;
   bit           route_bound [ROUTE_DEPTH];
   logic [15:0]  route_owner [ROUTE_DEPTH];

   pcar_req_type pending_req[$];
   bit           pending_pause[$];
   bit           pause_next = 1'b0;
   pcar_rsp_type routing_results[$];

   int           sent_count = 0;
   int           rsp_count = 0;
   int           errors = 0;
   int           send_gap = 0;
   int           hold_left = 0;
   bit           long_hold_done = 1'b0;
   int           rx_cycle = 0;
   logic [15:0]  bdf_pool [16];

   function automatic pcar_rsp_type routing_result(pcar_req_type r);
      pcar_rsp_type o;
      logic [15:0]  idx;
      o = '0;
      o.status = ST_OK;
      if (r.mode == MODE_REGISTER) begin
         idx = {r.bus_number, r.device_number, r.function_number};
         if (r.pci_segment != 16'd0) begin
            o.status = ST_BAD_SEGMENT;
         end else if (route_bound[idx]) begin
            o.status = ST_EXISTS;
         end else begin
            route_bound[idx] = 1'b1;
            route_owner[idx] = r.server_id;
         end
      end else if (r.port_offset == LATCH_OFFSET && r.access_bytes == LATCH_BYTES) begin
         if (r.is_write) cf8_latch = r.write_data;
         else o.read_data = cf8_latch;
      end else if (r.port_offset < DATA_OFFSET) begin
         o.status = ST_UNHANDLED;
      end else begin
         idx = cf8_latch[23:8];
         if (!route_bound[idx]) begin
            o.read_data = '1;
         end else begin
            o.forward_valid     = 1'b1;
            o.forward_server    = route_owner[idx];
            o.forward_address   = cf8_latch;
            o.forward_size_word = {r.port_offset[1:0], 13'd0, r.access_bytes};
         end
      end
      return o;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic pcar_req_type random_item();
      logic [95:0] raw;
      raw = {$urandom(), $urandom(), $urandom()};
      return pcar_req_type'(raw[$bits(pcar_req_type)-1:0]);
   endfunction

   function automatic pcar_req_type port_item(logic wr, logic [2:0] off, logic [2:0] nb,
                                              logic [31:0] wd);
      pcar_req_type r;
      r = random_item();
      r.mode         = MODE_PORT;
      r.is_write     = wr;
      r.port_offset  = off;
      r.access_bytes = nb;
      r.write_data   = wd;
      return r;
   endfunction

   function automatic pcar_req_type reg_item(logic [15:0] seg, logic [15:0] bdf,
                                             logic [15:0] sid);
      pcar_req_type r;
      r = random_item();
      r.mode        = MODE_REGISTER;
      r.pci_segment = seg;
      {r.bus_number, r.device_number, r.function_number} = bdf;
      r.server_id   = sid;
      return r;
   endfunction

   task automatic queue_req(pcar_req_type r);
      pending_req.push_back(r);
      pending_pause.push_back(pause_next);
      pause_next = 1'b0;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      logic fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            routing_results.push_back(routing_result(req_data));
            sent_count <= sent_count + 1;
            if (sent_count % 300 < 60) send_gap = 0;
            else send_gap = pick_gap();
         end
         if (fire || !req_valid) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_req.size() > 0 &&
                         (!pending_pause[0] || (!fire && sent_count == rsp_count))) begin
               req_data  <= pending_req.pop_front();
               void'(pending_pause.pop_front());
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      pcar_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (routing_results.size() == 0) begin
               $error("result transaction with none outstanding");
               errors++;
            end else begin
               want = routing_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("forward_valid", 32'(want.forward_valid),
                           32'(rsp_data.forward_valid));
               check_field("forward_server", 32'(want.forward_server),
                           32'(rsp_data.forward_server));
               check_field("forward_address", want.forward_address, rsp_data.forward_address);
               check_field("forward_size_word", 32'(want.forward_size_word),
                           32'(rsp_data.forward_size_word));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && rsp_count >= 300) begin
            long_hold_done = 1'b1;
            hold_left = 400;
            rsp_ready <= 1'b0;
         end else if (rx_cycle % 600 >= 150 && $urandom_range(3) == 0) begin
            hold_left = pick_gap();
            rsp_ready <= (hold_left == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int          kind;
      int          n;
      int          next_pause;
      logic [15:0] bdf;
      logic [2:0]  off;
      logic [2:0]  nb;
      int          pick;

      foreach (bdf_pool[i]) bdf_pool[i] = 16'($urandom());
      bdf_pool[0] = 16'h0000;
      bdf_pool[1] = 16'hffff;

      // directed: latch, data window miss, unhandled ports, registration codes, hits
      queue_req(port_item(1'b0, LATCH_OFFSET, LATCH_BYTES, 32'h0));
      queue_req(port_item(1'b0, DATA_OFFSET, 3'd4, 32'h0));
      queue_req(port_item(1'b1, LATCH_OFFSET, LATCH_BYTES, 32'hffff_ffff));
      queue_req(port_item(1'b0, LATCH_OFFSET, LATCH_BYTES, 32'h0));
      queue_req(port_item(1'b1, 3'd7, 3'd1, 32'h1234_5678));
      queue_req(port_item(1'b0, LATCH_OFFSET, 3'd2, 32'h0));
      queue_req(port_item(1'b1, 3'd1, 3'd4, 32'hdead_beef));
      queue_req(port_item(1'b0, 3'd3, 3'd1, 32'h0));
      queue_req(port_item(1'b1, LATCH_OFFSET, 3'd0, 32'h0));
      queue_req(port_item(1'b1, LATCH_OFFSET, 3'd7, 32'h0));
      queue_req(reg_item(16'hffff, 16'h1234, 16'h0042));
      queue_req(reg_item(16'h0000, 16'hffff, 16'hffff));
      queue_req(reg_item(16'h0001, 16'hffff, 16'h0001));
      queue_req(reg_item(16'h0000, 16'hffff, 16'h0002));
      queue_req(reg_item(16'h0000, 16'h0000, 16'h0000));
      queue_req(port_item(1'b0, DATA_OFFSET, 3'd4, 32'h0));
      queue_req(port_item(1'b1, 3'd7, 3'd7, 32'h5555_aaaa));
      queue_req(port_item(1'b0, 3'd5, 3'd0, 32'h0));
      queue_req(port_item(1'b1, LATCH_OFFSET, LATCH_BYTES, 32'h8000_0000));
      queue_req(port_item(1'b1, 3'd6, 3'd2, 32'hcafe_f00d));
      queue_req(port_item(1'b0, 3'd5, 3'd3, 32'h0));
      queue_req(port_item(1'b1, LATCH_OFFSET, LATCH_BYTES, 32'h0012_3400));
      queue_req(port_item(1'b0, DATA_OFFSET, 3'd2, 32'h0));

      // random: mostly latch-then-window sequences over a small pool of functions
      pause_next = 1'b1;
      next_pause = pending_req.size() + 200;
      while (pending_req.size() < TOTAL_ITEMS) begin
         if (pending_req.size() >= next_pause) begin
            pause_next = 1'b1;
            next_pause += $urandom_range(150, 300);
         end
         if ($urandom_range(19) == 0) bdf_pool[4'($urandom_range(15))] = 16'($urandom());
         bdf = ($urandom_range(9) < 8) ? bdf_pool[4'($urandom_range(15))] : 16'($urandom());
         kind = $urandom_range(99);
         if (kind < 20) begin
            queue_req(reg_item(($urandom_range(99) < 85) ? 16'h0 : 16'($urandom_range(1, 65535)),
                               bdf, 16'($urandom())));
         end else if (kind < 65) begin
            queue_req(port_item(1'b1, LATCH_OFFSET, LATCH_BYTES,
                                {8'($urandom()), bdf, 8'($urandom())}));
            n = $urandom_range(1, 3);
            repeat (n) begin
               pick = $urandom_range(9);
               if (pick < 3) nb = 3'd1;
               else if (pick < 5) nb = 3'd2;
               else if (pick < 7) nb = 3'd4;
               else nb = 3'($urandom_range(7));
               queue_req(port_item(1'($urandom()), 3'($urandom_range(4, 7)), nb,
                                   32'($urandom())));
            end
         end else if (kind < 75) begin
            queue_req(port_item(1'b0, LATCH_OFFSET, LATCH_BYTES, 32'($urandom())));
         end else if (kind < 85) begin
            off = 3'($urandom_range(0, 3));
            nb  = 3'($urandom_range(7));
            if (off == LATCH_OFFSET && nb == LATCH_BYTES) nb = 3'd1;
            queue_req(port_item(1'($urandom()), off, nb, 32'($urandom())));
         end else begin
            queue_req(random_item());
         end
      end

      @(negedge clock);
      while (reset) @(negedge clock);
      while (!(pending_req.size() == 0 && !req_valid && sent_count == rsp_count))
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (routing_results.size() != 0) begin
         $error("%0d result transactions never arrived", routing_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb_pci_config_access_router: PASS");
      end else begin
         $display("tb_pci_config_access_router: FAIL");
      end
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb_pci_config_access_router: FAIL");
      $finish;
   end

endmodule
